// ===== src/byte_stream_instruction_decoder_top_defines.svh =====
// Assertion macros used by the record queue of the decoder RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef BYTE_STREAM_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define BYTE_STREAM_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// Condition in this cycle implies another in the same cycle.
`define BSID_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bsid check failed");

// Condition in this cycle implies another in the next cycle.
`define BSID_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bsid check failed");

`endif

// ===== src/bsid_pkg.sv =====
// Types, constants and opcode tables of the byte stream instruction decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package bsid_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int TABLE_LEN  = 12;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_MODRM, PH_DISP_LO, PH_DISP_HI,
        PH_ADDR_LO, PH_ADDR_HI, PH_IMM_LO, PH_IMM_HI
    } phase_t;

    typedef enum logic [2:0] {
        CL_REGMEM, CL_IMM_RM, CL_IMM_REG, CL_ACC_MEM, CL_ACC_IMM, CL_GROUP
    } enc_class_t;

    localparam logic [2:0] K_REG     = 3'd0;
    localparam logic [2:0] K_DIRECT  = 3'd1;
    localparam logic [2:0] K_IMM     = 3'd2;
    localparam logic [2:0] K_MEM     = 3'd3;
    localparam logic [2:0] K_MEMDISP = 3'd4;

    localparam logic [1:0] OP_MOV = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_ADC = 2'd2;
    localparam logic [1:0] OP_SUB = 2'd3;

    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_ADC = 3'd2;
    localparam logic [2:0] GRP_SUB = 3'd5;

    localparam logic [7:0] OP_VALUE [TABLE_LEN] = '{
        8'h88, 8'hC6, 8'hB0, 8'hA0, 8'hA2, 8'h00,
        8'h80, 8'h04, 8'h14, 8'h10, 8'h28, 8'h2C};
    localparam logic [7:0] OP_MASK [TABLE_LEN] = '{
        8'hFC, 8'hFE, 8'hF0, 8'hFE, 8'hFE, 8'hFC,
        8'hFC, 8'hFE, 8'hFE, 8'hFC, 8'hFC, 8'hFE};
    localparam logic [1:0] OP_KIND_TAB [TABLE_LEN] = '{
        OP_MOV, OP_MOV, OP_MOV, OP_MOV, OP_MOV, OP_ADD,
        OP_ADD, OP_ADD, OP_ADC, OP_ADC, OP_SUB, OP_SUB};
    localparam enc_class_t OP_CLASS [TABLE_LEN] = '{
        CL_REGMEM, CL_IMM_RM, CL_IMM_REG, CL_ACC_MEM, CL_ACC_MEM, CL_REGMEM,
        CL_GROUP, CL_ACC_IMM, CL_ACC_IMM, CL_REGMEM, CL_REGMEM, CL_ACC_IMM};

    typedef struct packed {
        logic       hit;
        enc_class_t cls;
        logic [1:0] op;
    } op_match_t;

    // Record handed from the byte collector to the operand resolver.
    typedef struct packed {
        logic        err;
        enc_class_t  cls;
        logic [1:0]  op;
        logic        wide;
        logic        dir;
        logic [7:0]  modrm;
        logic [2:0]  low_reg;
        logic [15:0] disp;
        logic [15:0] addr;
        logic [15:0] imm;
        logic [2:0]  len;
    } raw_rec_t;

    // The lowest table index that matches wins.
    function automatic op_match_t match_opcode(logic [7:0] b);
        op_match_t m;
        m = '{hit: 1'b0, cls: CL_REGMEM, op: OP_MOV};
        for (int i = TABLE_LEN - 1; i >= 0; i--)
        begin
            if ((b & OP_MASK[i]) == OP_VALUE[i])
            begin
                m = '{hit: 1'b1, cls: OP_CLASS[i], op: OP_KIND_TAB[i]};
            end
        end
        return m;
    endfunction

    function automatic logic [2:0] ea_base(logic [2:0] rm);
        logic [2:0] r;
        case (rm)
            3'd0, 3'd1, 3'd7: r = 3'd3;
            3'd4:             r = 3'd6;
            3'd5:             r = 3'd7;
            default:          r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ea_index(logic [2:0] rm);
        logic [2:0] r;
        case (rm)
            3'd0, 3'd2: r = 3'd6;
            3'd1, 3'd3: r = 3'd7;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sext8(logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

`default_nettype wire

// ===== src/bsid_front.sv =====
// Byte collector: walks each instruction byte by byte and builds a raw record.
// Depends on bsid_pkg.
`default_nettype none

module bsid_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [7:0]         byte_in,
    output logic                    push,
    output bsid_pkg::raw_rec_t      rec
);
    import bsid_pkg::*;

    phase_t      phase_reg, phase_next;
    enc_class_t  cls_reg, cls_next;
    logic [1:0]  op_reg, op_next;
    logic        wide_reg, wide_next;
    logic        dir_reg, dir_next;
    logic        sign_reg, sign_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [2:0]  low_reg_reg, low_reg_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] imm_reg, imm_next;
    logic [2:0]  taken_reg, taken_next;

    op_match_t   m;
    logic        needs_imm, imm_word, grp_ok, emit, err;
    logic [1:0]  mod_in;

    assign m         = match_opcode(byte_in);
    assign mod_in    = byte_in[7:6];
    assign needs_imm = (cls_reg != CL_REGMEM) && (cls_reg != CL_ACC_MEM);
    assign imm_word  = (cls_reg == CL_GROUP) ? (!sign_reg && wide_reg) : wide_reg;
    assign grp_ok    = (byte_in[5:3] == GRP_ADD) || (byte_in[5:3] == GRP_ADC) ||
                       (byte_in[5:3] == GRP_SUB);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    if (m.hit)
                    begin
                        unique case (m.cls)
                            CL_IMM_REG, CL_ACC_IMM: phase_next = PH_IMM_LO;
                            CL_ACC_MEM:             phase_next = PH_ADDR_LO;
                            default:                phase_next = PH_MODRM;
                        endcase
                    end
                end
                PH_MODRM:
                begin
                    if (cls_reg == CL_GROUP && !grp_ok)
                        phase_next = PH_OPCODE;
                    else if (mod_in == 2'd0 && byte_in[2:0] == 3'd6)
                        phase_next = PH_ADDR_LO;
                    else if (mod_in == 2'd1 || mod_in == 2'd2)
                        phase_next = PH_DISP_LO;
                    else
                        phase_next = needs_imm ? PH_IMM_LO : PH_OPCODE;
                end
                PH_DISP_LO:
                begin
                    if (modrm_reg[7:6] == 2'd1)
                        phase_next = needs_imm ? PH_IMM_LO : PH_OPCODE;
                    else
                        phase_next = PH_DISP_HI;
                end
                PH_DISP_HI, PH_ADDR_HI: phase_next = needs_imm ? PH_IMM_LO : PH_OPCODE;
                PH_ADDR_LO:             phase_next = PH_ADDR_HI;
                PH_IMM_LO:              phase_next = imm_word ? PH_IMM_HI : PH_OPCODE;
                PH_IMM_HI:              phase_next = PH_OPCODE;
                default:                phase_next = PH_OPCODE;
            endcase
        end
    end

    // Held fields and the record emitted on the last byte.
    always_comb
    begin
        cls_next     = cls_reg;
        op_next      = op_reg;
        wide_next    = wide_reg;
        dir_next     = dir_reg;
        sign_next    = sign_reg;
        modrm_next   = modrm_reg;
        low_reg_next = low_reg_reg;
        disp_next    = disp_reg;
        addr_next    = addr_reg;
        imm_next     = imm_reg;
        taken_next   = taken_reg;
        err          = 1'b0;
        if (fire)
        begin
            taken_next = (phase_reg == PH_OPCODE) ? 3'd1 : taken_reg + 3'd1;
            unique case (phase_reg)
                PH_OPCODE:
                begin
                    modrm_next   = '0;
                    disp_next    = '0;
                    addr_next    = '0;
                    imm_next     = '0;
                    low_reg_next = '0;
                    dir_next     = 1'b0;
                    sign_next    = 1'b0;
                    cls_next     = m.hit ? m.cls : CL_REGMEM;
                    op_next      = m.hit ? m.op : OP_MOV;
                    wide_next    = m.hit & byte_in[0];
                    err          = !m.hit;
                    if (m.hit)
                    begin
                        unique case (m.cls)
                            CL_REGMEM: dir_next = byte_in[1];
                            CL_GROUP:  sign_next = byte_in[1];
                            CL_IMM_REG:
                            begin
                                wide_next    = byte_in[3];
                                low_reg_next = byte_in[2:0];
                            end
                            CL_ACC_MEM: dir_next = !byte_in[1];
                            CL_ACC_IMM: dir_next = 1'b1;
                            default:    dir_next = 1'b0;
                        endcase
                    end
                end
                PH_MODRM:
                begin
                    modrm_next = byte_in;
                    if (cls_reg == CL_GROUP)
                    begin
                        unique case (byte_in[5:3])
                            GRP_ADD: op_next = OP_ADD;
                            GRP_ADC: op_next = OP_ADC;
                            GRP_SUB: op_next = OP_SUB;
                            default: err = 1'b1;
                        endcase
                    end
                end
                PH_DISP_LO:
                    disp_next = (modrm_reg[7:6] == 2'd1) ? sext8(byte_in) : {8'h00, byte_in};
                PH_DISP_HI: disp_next = {byte_in, disp_reg[7:0]};
                PH_ADDR_LO: addr_next = {8'h00, byte_in};
                PH_ADDR_HI: addr_next = {byte_in, addr_reg[7:0]};
                PH_IMM_LO:  imm_next = imm_word ? {8'h00, byte_in} : sext8(byte_in);
                PH_IMM_HI:  imm_next = {byte_in, imm_reg[7:0]};
                default:    err = 1'b0;
            endcase
        end
    end

    // A record leaves whenever the collector returns to, or stays in, the opcode phase.
    assign emit = fire && (phase_next == PH_OPCODE);
    assign push = emit;
    assign rec  = '{err: err, cls: cls_next, op: op_next, wide: wide_next,
                    dir: dir_next, modrm: modrm_next, low_reg: low_reg_next,
                    disp: disp_next, addr: addr_next, imm: imm_next,
                    len: taken_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OPCODE;
            cls_reg     <= CL_REGMEM;
            op_reg      <= OP_MOV;
            wide_reg    <= 1'b0;
            dir_reg     <= 1'b0;
            sign_reg    <= 1'b0;
            modrm_reg   <= '0;
            low_reg_reg <= '0;
            disp_reg    <= '0;
            addr_reg    <= '0;
            imm_reg     <= '0;
            taken_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cls_reg     <= cls_next;
            op_reg      <= op_next;
            wide_reg    <= wide_next;
            dir_reg     <= dir_next;
            sign_reg    <= sign_next;
            modrm_reg   <= modrm_next;
            low_reg_reg <= low_reg_next;
            disp_reg    <= disp_next;
            addr_reg    <= addr_next;
            imm_reg     <= imm_next;
            taken_reg   <= taken_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bsid_fifo.sv =====
// Short record queue between the byte collector and the operand resolver.
// Depends on bsid_pkg and the assertion macro header.
`default_nettype none

module bsid_fifo #(
    parameter int DEPTH = bsid_pkg::FIFO_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bsid_pkg::raw_rec_t  wr_rec,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output bsid_pkg::raw_rec_t       rd_rec
);
    import bsid_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    raw_rec_t         mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_rec    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "byte_stream_instruction_decoder_top_defines.svh"

    `BSID_ASSERT_IMP(a_no_overflow, push, !full || pop)
    `BSID_ASSERT_IMP(a_no_underflow, pop, not_empty)
    `BSID_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `BSID_ASSERT_NXT(a_push_lands, push && !pop, not_empty)

endmodule

`default_nettype wire

// ===== src/bsid_back.sv =====
// Operand resolver: turns a raw record into the final decoded fields and
// holds them in the output register. Depends on bsid_pkg.
`default_nettype none

module bsid_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rec_valid,
    input  wire bsid_pkg::raw_rec_t  rec,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [71:0]              m_tdata,
    output logic                     m_tuser
);
    import bsid_pkg::*;

    logic [1:0]  mod;
    logic [2:0]  rm, regf;
    logic [2:0]  rm_kind, rm_reg, idx;
    logic [2:0]  dk, dr, sk, sr;
    logic [15:0] disp;
    logic        load;
    logic [71:0] data_next, data_reg;
    logic        bad_next, bad_reg;
    logic        valid_reg, valid_next;

    assign mod  = rec.modrm[7:6];
    assign regf = rec.modrm[5:3];
    assign rm   = rec.modrm[2:0];

    always_comb
    begin
        idx  = 3'd0;
        disp = '0;
        if (mod == 2'd3)
        begin
            rm_kind = K_REG;
            rm_reg  = rm;
        end
        else if (mod == 2'd0 && rm == 3'd6)
        begin
            rm_kind = K_DIRECT;
            rm_reg  = 3'd0;
        end
        else
        begin
            rm_kind = (mod == 2'd0) ? K_MEM : K_MEMDISP;
            rm_reg  = ea_base(rm);
            idx     = ea_index(rm);
            if (mod != 2'd0)
                disp = rec.disp;
        end

        unique case (rec.cls)
            CL_REGMEM:
            begin
                if (rec.dir)
                begin
                    dk = K_REG;   dr = regf;   sk = rm_kind; sr = rm_reg;
                end
                else
                begin
                    dk = rm_kind; dr = rm_reg; sk = K_REG;   sr = regf;
                end
            end
            CL_IMM_RM, CL_GROUP:
            begin
                dk = rm_kind; dr = rm_reg; sk = K_IMM; sr = 3'd0;
            end
            CL_IMM_REG:
            begin
                dk = K_REG; dr = rec.low_reg; sk = K_IMM; sr = 3'd0; idx = 3'd0;
            end
            CL_ACC_MEM:
            begin
                idx = 3'd0; dr = 3'd0; sr = 3'd0;
                dk  = rec.dir ? K_REG : K_DIRECT;
                sk  = rec.dir ? K_DIRECT : K_REG;
            end
            default:
            begin
                dk = K_REG; dr = 3'd0; sk = K_IMM; sr = 3'd0; idx = 3'd0;
            end
        endcase

        if (rec.err)
            data_next = {3'b000, rec.len, 66'd0};
        else
            data_next = {3'b000, rec.len, rec.imm, rec.addr, disp, idx,
                         sr, sk, dr, dk, rec.wide, rec.op};
        bad_next = rec.err;
    end

    // The output register takes a new record whenever it is empty or drained.
    assign load       = !valid_reg || m_tready;
    assign pop        = rec_valid && load;
    assign valid_next = load ? rec_valid : valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            bad_reg  <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = bad_reg;

endmodule

`default_nettype wire

// ===== src/byte_stream_instruction_decoder_top.sv =====
// Top level of the byte stream instruction decoder.
// Depends on bsid_pkg, bsid_front, bsid_fifo and bsid_back.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | s_tdata: one instruction byte
//  m_axis   | out       | m_tdata: decoded record, m_tuser: bad opcode flag
//
// One byte is taken per cycle while the queue is not full; a record is offered on
// m_tvalid after its last byte passes a queue entry, then the resolver register.
// The collector stalls only when the record queue is full; the queue
// fills only while the output is held back by m_tready.
// Reset returns the collector to the opcode phase and empties the queue.
`default_nettype none

module byte_stream_instruction_decoder_top #(
    parameter int FIFO_DEPTH = bsid_pkg::FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] op_kind, [2] wide, [5:3] dest_kind, [8:6] dest_reg, [11:9] src_kind,
    // [14:12] src_reg, [17:15] index_reg, [33:18] displacement,
    // [49:34] mem_address, [65:50] immediate_value, [68:66] instr_length
    output logic [71:0]      m_tdata,
    output logic             m_tuser    // [0] bad_opcode
);
    import bsid_pkg::*;

    logic     fire, push, pop, full, not_empty;
    raw_rec_t wr_rec, rd_rec;

    assign s_tready = !full;
    assign fire     = s_tvalid && s_tready;

    bsid_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .byte_in (s_tdata),
        .push    (push),
        .rec     (wr_rec)
    );

    bsid_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_rec    (wr_rec),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .rd_rec    (rd_rec)
    );

    bsid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (not_empty),
        .rec       (rd_rec),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
